FILE: design/keypad_code_lock_controller_top_macros.svh
// ----------------------------------------------------------------------------
// keypad code lock controller assertion macros
// shared assertion shorthands for the port checker
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_TOP_MACROS_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_TOP_MACROS_SVH

// clocked property, off during reset
`define KCLC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("kclc port check failed");

// property on every result word shown
`define KCLC_ASSERT_RSP(label, cond) \
   `KCLC_ASSERT(label, rsp_valid |-> (cond))

`endif

FILE: design/kclc_pkg.sv
// ----------------------------------------------------------------------------
// kclc_pkg
// constants, codes and types of the keypad code lock controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kclc_pkg;

   localparam int MAX_CODES   = 10;
   localparam int CODE_DIGITS = 4;
   localparam int MAX_OUT     = 10;

   localparam int ENTRY_W = 4 * CODE_DIGITS;
   localparam int ECNT_W  = $clog2(CODE_DIGITS + 1);
   localparam int CNT_W   = $clog2(MAX_CODES + 1);
   localparam int KEY_W   = 4;
   localparam int ATT_W   = 4;
   localparam int TICK_W  = 20;
   localparam int ST_W    = 5;
   localparam int DIG_W   = 16;
   localparam int LEN_W   = 3;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REG_IDX_LSB = 2;

   localparam logic [ATT_W-1:0]  ATT_RESET  = 4'd3;
   localparam logic [TICK_W-1:0] TICK_RESET = 20'd15000;

   localparam logic REG_MAX_ATTEMPTS  = 1'b0;
   localparam logic REG_LOCKOUT_TICKS = 1'b1;

   localparam logic ACT_KEY  = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_OUT  = 2'd0;
   localparam mode_type MODE_MENU = 2'd1;
   localparam mode_type MODE_ADD  = 2'd2;
   localparam mode_type MODE_DEL  = 2'd3;

   localparam logic [KEY_W-1:0] KEY_LAST_DIGIT = 4'd9;
   localparam logic [KEY_W-1:0] KEY_A          = 4'd10;
   localparam logic [KEY_W-1:0] KEY_B          = 4'd11;
   localparam logic [KEY_W-1:0] KEY_C          = 4'd12;
   localparam logic [KEY_W-1:0] KEY_D          = 4'd13;
   localparam logic [KEY_W-1:0] KEY_STAR       = 4'd14;
   localparam logic [KEY_W-1:0] KEY_HASH       = 4'd15;

   typedef logic [ST_W-1:0] status_type;
   localparam status_type ST_ACCEPTED        = 5'd0;
   localparam status_type ST_GRANTED         = 5'd1;
   localparam status_type ST_DENIED          = 5'd2;
   localparam status_type ST_DENIED_LOCKED   = 5'd3;
   localparam status_type ST_IGNORED_LOCKED  = 5'd4;
   localparam status_type ST_UNLOCKED        = 5'd5;
   localparam status_type ST_ADDED           = 5'd6;
   localparam status_type ST_FULL            = 5'd7;
   localparam status_type ST_BAD_LENGTH      = 5'd8;
   localparam status_type ST_REMOVED         = 5'd9;
   localparam status_type ST_NOT_FOUND       = 5'd10;
   localparam status_type ST_ADMIN_PROTECTED = 5'd11;
   localparam status_type ST_LOGGED_OFF      = 5'd12;
   localparam status_type ST_LIST_ENTRY      = 5'd13;
   localparam status_type ST_LIST_EMPTY      = 5'd14;
   localparam status_type ST_IDLE_TICK       = 5'd15;
   localparam status_type ST_MODE_ENTERED    = 5'd16;

   typedef logic [1:0] feed_type;
   localparam feed_type FEED_HEAD  = 2'd0;
   localparam feed_type FEED_WDATA = 2'd1;
   localparam feed_type FEED_NEXT  = 2'd2;

   typedef struct packed {
      logic               shift;
      feed_type           feed;
      logic [ENTRY_W-1:0] wdata;
   } chain_ctrl_type;

endpackage

`default_nettype wire

FILE: design/kclc_intf.sv
// ----------------------------------------------------------------------------
// kclc channel interfaces
// valid/ready channels for key words in and result words out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kclc_req_if import kclc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             action;
   logic [KEY_W-1:0] key_code;

   modport source (output valid, action, key_code, input ready);
   modport sink   (input valid, action, key_code, output ready);
endinterface

interface kclc_rsp_if import kclc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ST_W-1:0]  status;
   logic [DIG_W-1:0] entry_digits;
   logic [LEN_W-1:0] entry_length;
   logic             is_admin;
   logic             logged_in;
   logic             last;

   modport source (output valid, status, entry_digits, entry_length, is_admin, logged_in,
                   last, input ready);
   modport sink   (input valid, status, entry_digits, entry_length, is_admin, logged_in,
                   last, output ready);
endinterface

`default_nettype wire

FILE: design/kclc_code_cell.sv
// ----------------------------------------------------------------------------
// kclc_code_cell
// one stored code of the chain, loads its neighbor's code on a shift
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kclc_code_cell import kclc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               shift_en,
   input  wire logic [ENTRY_W-1:0] d,
   output logic      [ENTRY_W-1:0] q
);

   logic [ENTRY_W-1:0] code_ff;
   logic [ENTRY_W-1:0] code_in;

   always_comb begin
      code_in = shift_en ? d : code_ff;
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign q = code_ff;

endmodule

`default_nettype wire

FILE: design/kclc_code_chain.sv
// ----------------------------------------------------------------------------
// kclc_code_chain
// ring of code cells; each shift moves every code one place toward the head
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kclc_code_chain import kclc_pkg::*; (
   input  wire logic               clock,
   input  wire chain_ctrl_type     ctrl,
   output logic      [ENTRY_W-1:0] head
);

   logic [ENTRY_W-1:0] cell_q [MAX_CODES];
   logic [ENTRY_W-1:0] cell_d [MAX_CODES];
   logic [ENTRY_W-1:0] second;
   logic [ENTRY_W-1:0] feed_val;

   if (MAX_CODES > 1) begin : g_second
      assign second = cell_q[1];
   end else begin : g_no_second
      assign second = '0;
   end

   always_comb begin
      unique case (ctrl.feed)
         FEED_HEAD:  feed_val = cell_q[0];
         FEED_WDATA: feed_val = ctrl.wdata;
         FEED_NEXT:  feed_val = second;
         default:    feed_val = cell_q[0];
      endcase
   end

   for (genvar k = 0; k < MAX_CODES; k++) begin : g_cell
      if (k == MAX_CODES - 1) begin : g_tail
         assign cell_d[k] = feed_val;
      end else begin : g_body
         assign cell_d[k] = cell_q[k+1];
      end

      kclc_code_cell u_cell (
         .clock    (clock),
         .shift_en (ctrl.shift),
         .d        (cell_d[k]),
         .q        (cell_q[k])
      );
   end

   assign head = cell_q[0];

endmodule

`default_nettype wire

FILE: design/keypad_code_lock_controller_top.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_controller_top
// ticks, digits, star and mode keys give their word in the cycle after accept
// hash with a search or add walks the code chain once, word after the last step of the walk
// remove walks it twice, search then drop; list walks it once, one word a step per code
// throughput: one key or tick per cycle while the output is free; none is taken during a walk
// reset is synchronous: logged out, no codes, registers back to 3 and 15000
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keypad_code_lock_controller_top import kclc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   kclc_req_if.sink                   req_ch,
   kclc_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_ADD    = 3'd2;
   localparam logic [2:0] S_DROP   = 3'd3;
   localparam logic [2:0] S_LIST   = 3'd4;

   logic [2:0]         state_ff,   state_in;
   mode_type           mode_ff,    mode_in;
   logic [ENTRY_W-1:0] entry_ff,   entry_in;
   logic [ECNT_W-1:0]  ecount_ff,  ecount_in;
   logic [CNT_W-1:0]   count_ff,   count_in;
   logic               admin_rm_ff, admin_rm_in;
   logic [ATT_W-1:0]   failed_ff,  failed_in;
   logic [TICK_W-1:0]  lock_ff,    lock_in;
   logic [ATT_W-1:0]   max_att_ff, max_att_in;
   logic [TICK_W-1:0]  ticks_ff,   ticks_in;
   logic [CNT_W-1:0]   idx_ff,     idx_in;
   logic               found_ff,   found_in;
   logic [CNT_W-1:0]   fidx_ff,    fidx_in;
   logic               op_del_ff,  op_del_in;

   logic               out_valid_ff,  out_valid_in;
   status_type         out_status_ff, out_status_in;
   logic [DIG_W-1:0]   out_digits_ff, out_digits_in;
   logic [LEN_W-1:0]   out_len_ff,    out_len_in;
   logic               out_admin_ff,  out_admin_in;
   logic               out_login_ff,  out_login_in;
   logic               out_last_ff,   out_last_in;

   chain_ctrl_type     chain_ctrl;
   logic [ENTRY_W-1:0] head;

   logic               slot_free;
   logic               req_fire;
   logic               last_step;
   logic               head_hit;
   logic               found_now;
   logic [CNT_W-1:0]   fidx_now;
   logic [CNT_W-1:0]   idx_next;
   logic [ATT_W-1:0]   fail_next;
   logic               load;
   status_type         ld_status;
   logic               use_head;
   logic               ld_admin;
   logic               ld_last;
   logic               do_edit;
   logic               start_check;
   logic               csr_write;

   kclc_code_chain u_chain (
      .clock (clock),
      .ctrl  (chain_ctrl),
      .head  (head)
   );

   assign slot_free    = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && slot_free;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign last_step    = (idx_ff == CNT_W'(MAX_CODES - 1));
   assign head_hit     = (idx_ff < count_ff) && (head == entry_ff);
   assign found_now    = found_ff || head_hit;
   assign fidx_now     = found_ff ? fidx_ff : idx_ff;
   assign idx_next     = idx_ff + 1'b1;
   assign fail_next    = failed_ff + 1'b1;

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      entry_in    = entry_ff;
      ecount_in   = ecount_ff;
      count_in    = count_ff;
      admin_rm_in = admin_rm_ff;
      failed_in   = failed_ff;
      lock_in     = lock_ff;
      idx_in      = idx_ff;
      found_in    = found_ff;
      fidx_in     = fidx_ff;
      op_del_in   = op_del_ff;
      chain_ctrl.shift = 1'b0;
      chain_ctrl.feed  = FEED_HEAD;
      chain_ctrl.wdata = entry_ff;
      load        = 1'b0;
      ld_status   = ST_ACCEPTED;
      use_head    = 1'b0;
      ld_admin    = 1'b0;
      ld_last     = 1'b1;
      do_edit     = 1'b0;
      start_check = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_ch.action == ACT_TICK) begin
                  load = 1'b1;
                  ld_status = ST_IDLE_TICK;
                  if (lock_ff != '0) begin
                     lock_in = lock_ff - 1'b1;
                     if (lock_ff == TICK_W'(1)) begin
                        ld_status = ST_UNLOCKED;
                     end
                  end
               end else if (lock_ff != '0) begin
                  load = 1'b1;
                  ld_status = ST_IGNORED_LOCKED;
               end else if (mode_ff == MODE_OUT) begin
                  if (req_ch.key_code == KEY_HASH) begin
                     start_check = 1'b1;
                  end else begin
                     do_edit = 1'b1;
                  end
               end else begin
                  case (req_ch.key_code)
                     KEY_A: begin
                        mode_in = MODE_ADD;
                        entry_in = '0;
                        ecount_in = '0;
                        load = 1'b1;
                        ld_status = ST_MODE_ENTERED;
                     end
                     KEY_B: begin
                        mode_in = MODE_DEL;
                        entry_in = '0;
                        ecount_in = '0;
                        load = 1'b1;
                        ld_status = ST_MODE_ENTERED;
                     end
                     KEY_C: begin
                        mode_in = MODE_MENU;
                        if (count_ff == '0) begin
                           load = 1'b1;
                           ld_status = ST_LIST_EMPTY;
                        end else begin
                           state_in = S_LIST;
                           idx_in = '0;
                        end
                     end
                     KEY_D: begin
                        mode_in = MODE_OUT;
                        entry_in = '0;
                        ecount_in = '0;
                        load = 1'b1;
                        ld_status = ST_LOGGED_OFF;
                     end
                     KEY_HASH: begin
                        if (mode_ff == MODE_ADD) begin
                           if (ecount_ff != ECNT_W'(CODE_DIGITS)) begin
                              load = 1'b1;
                              ld_status = ST_BAD_LENGTH;
                              mode_in = MODE_MENU;
                              entry_in = '0;
                              ecount_in = '0;
                           end else if (count_ff < CNT_W'(MAX_CODES)) begin
                              state_in = S_ADD;
                              idx_in = '0;
                           end else begin
                              load = 1'b1;
                              ld_status = ST_FULL;
                              mode_in = MODE_MENU;
                              entry_in = '0;
                              ecount_in = '0;
                           end
                        end else if (mode_ff == MODE_DEL) begin
                           if (ecount_ff != ECNT_W'(CODE_DIGITS)) begin
                              load = 1'b1;
                              ld_status = ST_BAD_LENGTH;
                              mode_in = MODE_MENU;
                              entry_in = '0;
                              ecount_in = '0;
                           end else begin
                              state_in = S_SEARCH;
                              op_del_in = 1'b1;
                              idx_in = '0;
                              found_in = 1'b0;
                           end
                        end else begin
                           start_check = 1'b1;
                        end
                     end
                     default: begin
                        do_edit = 1'b1;
                     end
                  endcase
               end

               if (do_edit) begin
                  load = 1'b1;
                  ld_status = ST_ACCEPTED;
                  if (req_ch.key_code == KEY_STAR) begin
                     if (ecount_ff != '0) begin
                        entry_in = entry_ff >> 4;
                        ecount_in = ecount_ff - 1'b1;
                     end
                  end else if (req_ch.key_code <= KEY_LAST_DIGIT &&
                               ecount_ff < ECNT_W'(CODE_DIGITS)) begin
                     entry_in = ENTRY_W'({entry_ff, req_ch.key_code});
                     ecount_in = ecount_ff + 1'b1;
                  end
               end

               if (start_check) begin
                  if (!(ecount_ff == ECNT_W'(CODE_DIGITS) ||
                        (ecount_ff == '0 && count_ff == '0))) begin
                     load = 1'b1;
                     ld_status = ST_BAD_LENGTH;
                  end else if (count_ff == '0) begin
                     load = 1'b1;
                     ld_status = ST_GRANTED;
                     mode_in = MODE_MENU;
                     entry_in = '0;
                     ecount_in = '0;
                  end else begin
                     state_in = S_SEARCH;
                     op_del_in = 1'b0;
                     idx_in = '0;
                     found_in = 1'b0;
                  end
               end
            end
         end
         S_SEARCH: begin
            if (slot_free) begin
               chain_ctrl.shift = 1'b1;
               idx_in = idx_next;
               if (!found_ff && head_hit) begin
                  found_in = 1'b1;
                  fidx_in = idx_ff;
               end
               if (last_step) begin
                  state_in = S_IDLE;
                  idx_in = '0;
                  if (!op_del_ff) begin
                     load = 1'b1;
                     entry_in = '0;
                     ecount_in = '0;
                     if (found_now) begin
                        mode_in = MODE_MENU;
                        ld_status = ST_GRANTED;
                     end else if (fail_next >= max_att_ff) begin
                        lock_in = ticks_ff;
                        failed_in = '0;
                        ld_status = ST_DENIED_LOCKED;
                     end else begin
                        failed_in = fail_next;
                        ld_status = ST_DENIED;
                     end
                  end else if (!found_now) begin
                     load = 1'b1;
                     ld_status = ST_NOT_FOUND;
                     mode_in = MODE_MENU;
                     entry_in = '0;
                     ecount_in = '0;
                  end else if (fidx_now == '0 && !admin_rm_ff) begin
                     load = 1'b1;
                     ld_status = ST_ADMIN_PROTECTED;
                     mode_in = MODE_MENU;
                     entry_in = '0;
                     ecount_in = '0;
                  end else begin
                     state_in = S_DROP;
                     fidx_in = fidx_now;
                  end
               end
            end
         end
         S_ADD: begin
            if (slot_free) begin
               chain_ctrl.shift = 1'b1;
               chain_ctrl.feed = (idx_ff == count_ff) ? FEED_WDATA : FEED_HEAD;
               idx_in = idx_next;
               if (last_step) begin
                  state_in = S_IDLE;
                  idx_in = '0;
                  count_in = count_ff + 1'b1;
                  mode_in = MODE_MENU;
                  entry_in = '0;
                  ecount_in = '0;
                  load = 1'b1;
                  ld_status = ST_ADDED;
               end
            end
         end
         S_DROP: begin
            if (slot_free) begin
               chain_ctrl.shift = 1'b1;
               chain_ctrl.feed = (idx_ff >= fidx_ff) ? FEED_NEXT : FEED_HEAD;
               idx_in = idx_next;
               if (last_step) begin
                  state_in = S_IDLE;
                  idx_in = '0;
                  count_in = count_ff - 1'b1;
                  admin_rm_in = admin_rm_ff || (fidx_ff == '0);
                  mode_in = MODE_MENU;
                  entry_in = '0;
                  ecount_in = '0;
                  load = 1'b1;
                  ld_status = ST_REMOVED;
               end
            end
         end
         S_LIST: begin
            if (slot_free) begin
               chain_ctrl.shift = 1'b1;
               idx_in = idx_next;
               if (idx_ff < count_ff && 32'(idx_ff) < MAX_OUT) begin
                  load = 1'b1;
                  ld_status = ST_LIST_ENTRY;
                  use_head = 1'b1;
                  ld_admin = (idx_ff == '0) && !admin_rm_ff;
                  ld_last = (idx_next == count_ff) || (32'(idx_next) == MAX_OUT);
               end
               if (last_step) begin
                  state_in = S_IDLE;
                  idx_in = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in  = load || (out_valid_ff && !rsp_ch.ready);
      out_status_in = load ? ld_status : out_status_ff;
      out_digits_in = out_digits_ff;
      out_len_in    = out_len_ff;
      out_admin_in  = out_admin_ff;
      out_login_in  = out_login_ff;
      out_last_in   = out_last_ff;
      if (load) begin
         out_digits_in = use_head ? DIG_W'(head) : DIG_W'(entry_in);
         out_len_in    = LEN_W'(ecount_in);
         out_admin_in  = ld_admin;
         out_login_in  = (mode_in != MODE_OUT);
         out_last_in   = ld_last;
      end
   end

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      max_att_in = max_att_ff;
      ticks_in   = ticks_ff;
      if (csr_write) begin
         unique case (csr_paddr[REG_IDX_LSB])
            REG_MAX_ATTEMPTS:  max_att_in = csr_pwdata[ATT_W-1:0];
            REG_LOCKOUT_TICKS: ticks_in = csr_pwdata[TICK_W-1:0];
            default:           max_att_in = max_att_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[REG_IDX_LSB])
         REG_MAX_ATTEMPTS:  csr_prdata = CSR_DATA_W'(max_att_ff);
         REG_LOCKOUT_TICKS: csr_prdata = CSR_DATA_W'(ticks_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_OUT;
         entry_ff     <= '0;
         ecount_ff    <= '0;
         count_ff     <= '0;
         admin_rm_ff  <= 1'b0;
         failed_ff    <= '0;
         lock_ff      <= '0;
         max_att_ff   <= ATT_RESET;
         ticks_ff     <= TICK_RESET;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         entry_ff     <= entry_in;
         ecount_ff    <= ecount_in;
         count_ff     <= count_in;
         admin_rm_ff  <= admin_rm_in;
         failed_ff    <= failed_in;
         lock_ff      <= lock_in;
         max_att_ff   <= max_att_in;
         ticks_ff     <= ticks_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff      <= found_in;
      fidx_ff       <= fidx_in;
      op_del_ff     <= op_del_in;
      out_status_ff <= out_status_in;
      out_digits_ff <= out_digits_in;
      out_len_ff    <= out_len_in;
      out_admin_ff  <= out_admin_in;
      out_login_ff  <= out_login_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.status       = out_status_ff;
   assign rsp_ch.entry_digits = out_digits_ff;
   assign rsp_ch.entry_length = out_len_ff;
   assign rsp_ch.is_admin     = out_admin_ff;
   assign rsp_ch.logged_in    = out_login_ff;
   assign rsp_ch.last         = out_last_ff;

endmodule

`default_nettype wire

FILE: design/kclc_checker.sv
// ----------------------------------------------------------------------------
// kclc_checker
// port level checks on the result channel of the code lock controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "keypad_code_lock_controller_top_macros.svh"

module kclc_checker import kclc_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [ST_W-1:0]  rsp_status,
   input wire logic [DIG_W-1:0] rsp_entry_digits,
   input wire logic [LEN_W-1:0] rsp_entry_length,
   input wire logic             rsp_is_admin,
   input wire logic             rsp_logged_in,
   input wire logic             rsp_last
);

   // a stalled word holds
   `KCLC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_entry_digits) && $stable(rsp_last))

   // only a listed code can carry the admin mark
   `KCLC_ASSERT_RSP(a_admin_list, !rsp_is_admin || rsp_status == ST_LIST_ENTRY)

   // login always leaves the entry buffer empty and the user in
   `KCLC_ASSERT_RSP(a_granted, rsp_status != ST_GRANTED || (rsp_logged_in && rsp_entry_length == '0))

   // log off always leaves the user out with an empty entry
   `KCLC_ASSERT_RSP(a_logoff, rsp_status != ST_LOGGED_OFF || (!rsp_logged_in && rsp_entry_length == '0))

endmodule

bind keypad_code_lock_controller_top kclc_checker u_kclc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_entry_digits (rsp_ch.entry_digits),
   .rsp_entry_length (rsp_ch.entry_length),
   .rsp_is_admin     (rsp_ch.is_admin),
   .rsp_logged_in    (rsp_ch.logged_in),
   .rsp_last         (rsp_ch.last)
);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad code lock controller testbench
// drives key and tick words through the request channel, predicts every
// result word from a behavioral copy of the lock and compares field by field
// ----------------------------------------------------------------------------

module testbench;
   import kclc_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 2 * MAX_CODES + 8;
   localparam int LONG_LOCK     = 200;
   localparam int IDLE_PCT      = 15;

   typedef struct packed {
      status_type       status;
      logic [DIG_W-1:0] digits;
      logic [LEN_W-1:0] len;
      logic             admin;
      logic             logged;
      logic             last;
   } lock_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   kclc_req_if req_bus ();
   kclc_rsp_if rsp_bus ();

   keypad_code_lock_controller_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // lock state as predicted
   mode_type           ui_mode    = MODE_OUT;
   logic [ENTRY_W-1:0] entry_buf  = '0;
   logic [LEN_W-1:0]   entry_cnt  = '0;
   logic [ENTRY_W-1:0] codes [MAX_CODES];
   int                 code_cnt   = 0;
   logic               admin_gone = 1'b0;
   logic [ATT_W-1:0]   fail_cnt   = '0;
   logic [TICK_W-1:0]  lock_left  = '0;
   logic [ATT_W-1:0]   cfg_attempts   = ATT_RESET;
   logic [TICK_W-1:0]  cfg_lock_ticks = TICK_RESET;

   lock_word_type pending_words [$];

   int          error_count = 0;
   int          words_sent  = 0;
   int          hold_left   = 0;
   bit          idle_on     = 1'b1;
   int unsigned cycle_count = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("keypad_code_lock_controller_top: mismatch");
         $finish;
      end
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("error at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   // ---------------- prediction ----------------

   function automatic int find_code(logic [ENTRY_W-1:0] code);
      for (int i = 0; i < code_cnt; i++)
         if (codes[i] == code) return i;
      return -1;
   endfunction

   task automatic post(status_type st, logic [ENTRY_W-1:0] dig, logic adm, logic lst);
      pending_words.push_back('{st, dig, entry_cnt, adm, ui_mode != MODE_OUT, lst});
   endtask

   function automatic void clear_entry();
      entry_buf = '0;
      entry_cnt = '0;
   endfunction

   function automatic void edit_entry(logic [KEY_W-1:0] key);
      if (key == KEY_STAR) begin
         if (entry_cnt != 0) begin
            entry_buf = entry_buf >> 4;
            entry_cnt--;
         end
      end else if (key <= KEY_LAST_DIGIT && entry_cnt < CODE_DIGITS) begin
         entry_buf = {entry_buf[ENTRY_W-5:0], key};
         entry_cnt++;
      end
   endfunction

   function automatic status_type verify_entry();
      logic ok;
      if (!(entry_cnt == CODE_DIGITS || (entry_cnt == 0 && code_cnt == 0)))
         return ST_BAD_LENGTH;
      ok = (code_cnt == 0) || (find_code(entry_buf) >= 0);
      clear_entry();
      if (ok) begin
         ui_mode = MODE_MENU;
         return ST_GRANTED;
      end
      fail_cnt = fail_cnt + 1'b1;
      if (fail_cnt >= cfg_attempts) begin
         lock_left = cfg_lock_ticks;
         fail_cnt  = '0;
         return ST_DENIED_LOCKED;
      end
      return ST_DENIED;
   endfunction

   function automatic status_type store_entry();
      status_type st;
      if (entry_cnt != CODE_DIGITS) begin
         st = ST_BAD_LENGTH;
      end else if (code_cnt < MAX_CODES) begin
         codes[code_cnt] = entry_buf;
         code_cnt++;
         st = ST_ADDED;
      end else begin
         st = ST_FULL;
      end
      ui_mode = MODE_MENU;
      clear_entry();
      return st;
   endfunction

   function automatic status_type drop_entry();
      status_type st;
      int         idx;
      st = ST_BAD_LENGTH;
      if (entry_cnt == CODE_DIGITS) begin
         idx = find_code(entry_buf);
         if (idx < 0) begin
            st = ST_NOT_FOUND;
         end else if (idx == 0 && !admin_gone) begin
            st = ST_ADMIN_PROTECTED;
         end else begin
            for (int j = idx; j + 1 < code_cnt; j++) codes[j] = codes[j + 1];
            code_cnt--;
            if (idx == 0) admin_gone = 1'b1;
            st = ST_REMOVED;
         end
      end
      ui_mode = MODE_MENU;
      clear_entry();
      return st;
   endfunction

   task automatic predict_word(logic act, logic [KEY_W-1:0] key);
      status_type st;
      st = ST_ACCEPTED;
      if (act == ACT_TICK) begin
         st = ST_IDLE_TICK;
         if (lock_left != 0) begin
            lock_left--;
            if (lock_left == 0) st = ST_UNLOCKED;
         end
      end else if (lock_left != 0) begin
         st = ST_IGNORED_LOCKED;
      end else if (ui_mode == MODE_OUT) begin
         if (key == KEY_HASH) st = verify_entry();
         else edit_entry(key);
      end else begin
         case (key)
            KEY_A: begin
               ui_mode = MODE_ADD;
               clear_entry();
               st = ST_MODE_ENTERED;
            end
            KEY_B: begin
               ui_mode = MODE_DEL;
               clear_entry();
               st = ST_MODE_ENTERED;
            end
            KEY_C: begin
               ui_mode = MODE_MENU;
               if (code_cnt == 0) begin
                  post(ST_LIST_EMPTY, entry_buf, 1'b0, 1'b1);
               end else begin
                  for (int i = 0; i < code_cnt; i++)
                     post(ST_LIST_ENTRY, codes[i], i == 0 && !admin_gone, i == code_cnt - 1);
               end
               return;
            end
            KEY_D: begin
               ui_mode = MODE_OUT;
               clear_entry();
               st = ST_LOGGED_OFF;
            end
            KEY_HASH: begin
               if (ui_mode == MODE_ADD) st = store_entry();
               else if (ui_mode == MODE_DEL) st = drop_entry();
               else st = verify_entry();
            end
            default: edit_entry(key);
         endcase
      end
      post(st, entry_buf, 1'b0, 1'b1);
   endtask

   // ---------------- request side ----------------

   task automatic send_word(logic act, logic [KEY_W-1:0] key_in);
      logic [KEY_W-1:0] key;
      bit               acc;
      key = key_in;
      // keep a failed login from starting a lockout too long to tick out
      if (act == ACT_KEY && key == KEY_HASH && cfg_lock_ticks > LONG_LOCK && lock_left == 0
          && (ui_mode == MODE_OUT || ui_mode == MODE_MENU) && entry_cnt == CODE_DIGITS
          && code_cnt != 0 && find_code(entry_buf) < 0
          && ATT_W'(fail_cnt + 1'b1) >= cfg_attempts)
         key = KEY_STAR;
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.action   <= act;
      req_bus.key_code <= key;
      do begin
         @(negedge clock);
         acc = req_bus.ready;
         @(posedge clock);
      end while (!acc);
      predict_word(act, key);
      words_sent++;
   endtask

   task automatic wait_results_done();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << REG_IDX_LSB;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_MAX_ATTEMPTS) cfg_attempts = value[ATT_W-1:0];
      else cfg_lock_ticks = value[TICK_W-1:0];
   endtask

   task automatic apply_settings(int attempts, int ticks);
      wait_results_done();
      csr_write(REG_MAX_ATTEMPTS, attempts);
      csr_write(REG_LOCKOUT_TICKS, ticks);
   endtask

   function automatic logic [ENTRY_W-1:0] any_code();
      logic [ENTRY_W-1:0] c;
      c = '0;
      for (int i = 0; i < CODE_DIGITS; i++) c = {c[ENTRY_W-5:0], 4'($urandom_range(9))};
      return c;
   endfunction

   function automatic logic [ENTRY_W-1:0] pick_code(int known_pct);
      if (code_cnt != 0 && $urandom_range(99) < known_pct)
         return codes[$urandom_range(code_cnt - 1)];
      return any_code();
   endfunction

   task automatic send_code(logic [ENTRY_W-1:0] code, int ndig);
      for (int i = 0; i < ndig; i++) send_word(ACT_KEY, code[ENTRY_W-1-4*i -: 4]);
   endtask

   // mostly well formed sessions with random content, some noise
   task automatic run_sessions(int n);
      int stop;
      int r;
      stop = words_sent + n;
      while (words_sent < stop) begin
         r = $urandom_range(99);
         if (lock_left != 0) begin
            if (r < 80) send_word(ACT_TICK, 4'($urandom_range(15)));
            else send_word(ACT_KEY, 4'($urandom_range(15)));
         end else if (r < 8) begin
            send_word(1'($urandom_range(1)), 4'($urandom_range(15)));
         end else if (r < 14) begin
            send_word(ACT_TICK, 4'($urandom_range(15)));
         end else if (ui_mode == MODE_OUT) begin
            if (r < 24) begin
               send_word(ACT_KEY, 4'($urandom_range(9)));
               send_word(ACT_KEY, KEY_STAR);
            end
            if (code_cnt == 0 && r < 60) begin
               send_word(ACT_KEY, KEY_HASH);
            end else begin
               send_code(pick_code(70), (r % 10 == 0) ? 3 : 4);
               send_word(ACT_KEY, KEY_HASH);
            end
         end else begin
            r = $urandom_range(99);
            if (r < 35) begin
               send_word(ACT_KEY, KEY_A);
               send_code(pick_code(15), (r < 4) ? 3 : 4);
               if (r % 7 == 0) send_word(ACT_KEY, 4'($urandom_range(9)));
               send_word(ACT_KEY, KEY_HASH);
            end else if (r < 55) begin
               send_word(ACT_KEY, KEY_B);
               send_code(pick_code(60), 4);
               send_word(ACT_KEY, KEY_HASH);
            end else if (r < 70) begin
               send_word(ACT_KEY, KEY_C);
            end else if (r < 80) begin
               send_word(ACT_KEY, KEY_D);
            end else if (r < 90) begin
               send_code(pick_code(40), 4);
               send_word(ACT_KEY, KEY_HASH);
            end else begin
               send_word(ACT_KEY, 4'($urandom_range(9)));
               send_word(ACT_KEY, KEY_STAR);
               send_word(ACT_KEY, KEY_STAR);
            end
         end
      end
   endtask

   // ---------------- result side ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready <= !idle_on || $urandom_range(99) >= IDLE_PCT;
      end
   end

   always @(negedge clock) begin
      lock_word_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected word, status", rsp_bus.status, -1);
         end else begin
            want = pending_words.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch("status", rsp_bus.status, want.status);
            if (rsp_bus.entry_digits !== want.digits)
               report_mismatch("entry_digits", rsp_bus.entry_digits, want.digits);
            if (rsp_bus.entry_length !== want.len)
               report_mismatch("entry_length", rsp_bus.entry_length, want.len);
            if (rsp_bus.is_admin !== want.admin)
               report_mismatch("is_admin", rsp_bus.is_admin, want.admin);
            if (rsp_bus.logged_in !== want.logged)
               report_mismatch("logged_in", rsp_bus.logged_in, want.logged);
            if (rsp_bus.last !== want.last)
               report_mismatch("last", rsp_bus.last, want.last);
         end
      end
   end

   // ---------------- tests ----------------

   task automatic test_directed_flow();
      apply_settings(1, 2);
      // bad length, star edits, empty store login
      send_word(ACT_KEY, 4'd1);
      send_word(ACT_KEY, KEY_HASH);
      send_word(ACT_KEY, KEY_STAR);
      send_word(ACT_KEY, KEY_STAR);
      send_word(ACT_KEY, KEY_HASH);
      send_word(ACT_KEY, KEY_C);
      // add admin code, fifth digit on a full buffer
      send_word(ACT_KEY, KEY_A);
      send_code(16'h1234, 4);
      send_word(ACT_KEY, 4'd5);
      send_word(ACT_KEY, KEY_HASH);
      // admin code is protected
      send_word(ACT_KEY, KEY_B);
      send_code(16'h1234, 4);
      send_word(ACT_KEY, KEY_HASH);
      send_word(ACT_KEY, KEY_D);
      send_word(ACT_KEY, KEY_A);
      // wrong code locks out, keys ignored, ticks unlock
      send_code(16'h9999, 4);
      send_word(ACT_KEY, KEY_HASH);
      send_word(ACT_KEY, 4'd7);
      send_word(ACT_TICK, 4'd0);
      send_word(ACT_TICK, 4'd15);
      send_word(ACT_TICK, 4'd10);
   endtask

   task automatic test_random_settings();
      apply_settings(3, 5);
      run_sessions(45);
      apply_settings(15, 1048575);
      idle_on = 1'b0;
      run_sessions(45);
      idle_on = 1'b1;
      apply_settings(0, 0);
      run_sessions(45);
      apply_settings(1, 1);
      run_sessions(45);
   endtask

   task automatic test_backpressure();
      apply_settings(2, 3);
      hold_left = 400;
      run_sessions(40);
      wait_results_done();
      run_sessions(20);
   endtask

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.action   = ACT_KEY;
      req_bus.key_code = '0;
      rsp_bus.ready    = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_flow();
      test_random_settings();
      test_backpressure();
      wait_results_done();
      if (pending_words.size() != 0)
         report_mismatch("words never received", 0, pending_words.size());
      if (error_count == 0) begin
         $display("keypad_code_lock_controller_top: match");
      end else begin
         $display("keypad_code_lock_controller_top: mismatch");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/kclc_pkg.sv
design/kclc_intf.sv
design/kclc_code_cell.sv
design/kclc_code_chain.sv
design/keypad_code_lock_controller_top.sv
design/kclc_checker.sv
tb/testbench.sv
